### sv/adc_average_to_millivolts_macros.svh
// Assertion helpers shared by the RTL files of the averaging block.
// In synthesis builds the macros expand to nothing.
`ifndef ADC_AVERAGE_TO_MILLIVOLTS_MACROS_SVH
`define ADC_AVERAGE_TO_MILLIVOLTS_MACROS_SVH

`ifndef SYNTHESIS
`define AAM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define AAM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AAM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define AAM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/aam_pkg.sv
`default_nettype none

package aam_pkg;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int AVG_SHIFT_W = 3;
	localparam int TOL_W       = 13;
	localparam int MV_W        = 16;
	localparam int MULT_W      = 13;
	localparam int TUSER_OUT_W = 3;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_AVG_SHIFT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_TOL   = 2'd1;

	localparam logic [AVG_SHIFT_W-1:0] AVG_SHIFT_RESET = 3'd4;
	localparam logic [TOL_W-1:0]       TOL_RESET       = 13'd200;

	localparam logic [MULT_W-1:0] REFERENCE_MULT = 13'd5000;
	localparam logic [MV_W-1:0]   REFERENCE_MV   = 16'd5000;
	localparam logic [MV_W-1:0]   MV_LIMIT       = 16'hFFFF;
	localparam int                BANDGAP_MV     = 1100;

	// Channel tracking: ground selects neither input after reset.
	localparam logic [1:0] NO_CHANNEL = 2'd2;

	// Bit positions inside the result tuser.
	localparam int TU_CHANNEL = 0;
	localparam int TU_REF_OK  = 1;
	localparam int TU_SAT     = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_DONE
	} aam_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

### sv/adc_average_to_millivolts.sv
// Channel   Direction  Word contents
// s_*       in         tdata: sample; tuser: channel (0 battery, 1 bandgap)
// m_*       out        tdata: millivolts; tuser: result_channel, ref_ok, saturated
// cfg_*     in         cfg_index selects the register, cfg_data holds the value
//
// A sample that does not complete a measurement leaves s_tready high. A completing
// sample holds s_tready low through the calculate, divide and done states while the
// bit-serial divider runs; a zero supply average skips the divider.
// s_tready also stays low while a stalled word still holds the output register.
// Reset clears the sequencer, the sum, the count and the channel memory; the
// first sample after reset is a settling read.
`default_nettype none

`include "adc_average_to_millivolts_macros.svh"

module adc_average_to_millivolts #(
	parameter int SAMPLE_BITS   = 10,
	parameter int MAX_AVG_SHIFT = 7
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // [sample]
	input  wire logic                                    s_tuser,  // [channel]
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	output logic [aam_pkg::MV_W-1:0]                     m_tdata,  // [millivolts]
	// [result_channel, ref_ok, saturated]
	output logic [aam_pkg::TUSER_OUT_W-1:0]              m_tuser,
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic [aam_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [aam_pkg::CFG_DATA_W-1:0]          cfg_data
);

	localparam int SUM_W      = SAMPLE_BITS + MAX_AVG_SHIFT;
	localparam int DIVIDEND_W = SUM_W + aam_pkg::MULT_W;
	localparam logic [SUM_W-1:0] FULL_SCALE = SUM_W'(2 ** SAMPLE_BITS - 1);
	localparam logic [DIVIDEND_W-1:0] SUPPLY_NUM =
		DIVIDEND_W'((2 ** SAMPLE_BITS - 1) * aam_pkg::BANDGAP_MV);

	aam_pkg::aam_state_t state_q, state_nxt;

	logic [aam_pkg::AVG_SHIFT_W-1:0] avg_shift_q;
	logic [aam_pkg::TOL_W-1:0]       tol_q;
	logic                            s_acc;
	logic                            acc_done;
	logic [SUM_W-1:0]                acc_avg;
	logic [SUM_W-1:0]                avg_q;
	logic                            ch_q;
	logic                            avg_zero;
	logic                            div_start;
	logic [DIVIDEND_W-1:0]           dividend;
	logic [SUM_W-1:0]                divisor;
	logic [DIVIDEND_W-1:0]           quotient;
	aam_pkg::div_stat_t              div_stat;
	logic [aam_pkg::MV_W-1:0]        mv_q;
	logic                            sat_q;
	logic [aam_pkg::MV_W-1:0]        diff;
	logic                            ok;
	logic                            out_free;
	logic                            load_out;
	logic                            m_tvalid_q;
	logic [aam_pkg::MV_W-1:0]        m_tdata_q;
	logic [aam_pkg::TUSER_OUT_W-1:0] m_tuser_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_shift_q <= aam_pkg::AVG_SHIFT_RESET;
			tol_q       <= aam_pkg::TOL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				aam_pkg::REG_AVG_SHIFT: avg_shift_q <= cfg_data[aam_pkg::AVG_SHIFT_W-1:0];
				aam_pkg::REG_REF_TOL:   tol_q       <= cfg_data[aam_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_acc = s_tvalid && s_tready;

	aam_accum #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.MAX_AVG_SHIFT(MAX_AVG_SHIFT)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (s_acc),
		.sample   (s_tdata[SAMPLE_BITS-1:0]),
		.channel  (s_tuser),
		.avg_shift(avg_shift_q),
		.done     (acc_done),
		.avg      (acc_avg)
	);

	always_ff @(posedge clk) begin
		if (s_acc && acc_done) begin
			avg_q <= acc_avg;
			ch_q  <= s_tuser;
		end
	end

	assign avg_zero = (avg_q == '0);

	// Battery: avg * 5000 / full scale. Supply: full scale * 1100 / avg.
	always_comb begin
		if (ch_q) begin
			dividend = SUPPLY_NUM;
			divisor  = avg_q;
		end else begin
			dividend = DIVIDEND_W'(avg_q) * DIVIDEND_W'(aam_pkg::REFERENCE_MULT);
			divisor  = FULL_SCALE;
		end
	end

	aam_div #(
		.N_W(DIVIDEND_W),
		.D_W(SUM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend),
		.divisor (divisor),
		.quotient(quotient),
		.stat    (div_stat)
	);

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			aam_pkg::ST_IDLE: if (s_acc && acc_done) state_nxt = aam_pkg::ST_CALC;
			aam_pkg::ST_CALC: state_nxt = (ch_q && avg_zero) ? aam_pkg::ST_DONE : aam_pkg::ST_DIV;
			aam_pkg::ST_DIV:  if (div_stat.done) state_nxt = aam_pkg::ST_DONE;
			aam_pkg::ST_DONE: if (out_free) state_nxt = aam_pkg::ST_IDLE;
			default:          state_nxt = aam_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			aam_pkg::ST_IDLE: s_tready = 1'b1;
			aam_pkg::ST_CALC: div_start = !(ch_q && avg_zero);
			aam_pkg::ST_DIV:  ;
			aam_pkg::ST_DONE: load_out = out_free;
			default:          ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aam_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == aam_pkg::ST_CALC && ch_q && avg_zero) begin
			mv_q  <= aam_pkg::MV_LIMIT;
			sat_q <= 1'b1;
		end else if (state_q == aam_pkg::ST_DIV && div_stat.done) begin
			if (|quotient[DIVIDEND_W-1:aam_pkg::MV_W]) begin
				mv_q  <= aam_pkg::MV_LIMIT;
				sat_q <= 1'b1;
			end else begin
				mv_q  <= quotient[aam_pkg::MV_W-1:0];
				sat_q <= 1'b0;
			end
		end
	end

	// A saturated word is far outside any 13-bit tolerance, so it is never ok.
	always_comb begin
		diff = (mv_q >= aam_pkg::REFERENCE_MV) ? (mv_q - aam_pkg::REFERENCE_MV)
			: (aam_pkg::REFERENCE_MV - mv_q);
		ok   = ch_q && (diff < aam_pkg::MV_W'(tol_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q                      <= mv_q;
			m_tuser_q[aam_pkg::TU_CHANNEL] <= ch_q;
			m_tuser_q[aam_pkg::TU_REF_OK]  <= ok;
			m_tuser_q[aam_pkg::TU_SAT]     <= sat_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`AAM_ASSERT_IMP(a_div_done_in_div, clk, arst_n, div_stat.done,
		state_q == aam_pkg::ST_DIV, "divider finished outside the divide state")
	`AAM_ASSERT_IMP(a_ok_only_supply, clk, arst_n,
		m_tvalid && m_tuser[aam_pkg::TU_REF_OK],
		m_tuser[aam_pkg::TU_CHANNEL] && !m_tuser[aam_pkg::TU_SAT],
		"ref_ok on a battery or saturated word")
	`AAM_ASSERT_IMP(a_busy_not_ready, clk, arst_n, div_stat.busy, !s_tready,
		"sample accepted while the divider runs")

endmodule

`default_nettype wire

### sv/aam_accum.sv
`default_nettype none

module aam_accum #(
	parameter int SAMPLE_BITS   = 10,
	parameter int MAX_AVG_SHIFT = 7
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     accept,
	input  wire logic [SAMPLE_BITS-1:0]                   sample,
	input  wire logic                                     channel,
	input  wire logic [aam_pkg::AVG_SHIFT_W-1:0]          avg_shift,
	output logic                                          done,
	output logic [SAMPLE_BITS+MAX_AVG_SHIFT-1:0]          avg
);

	localparam int SUM_W = SAMPLE_BITS + MAX_AVG_SHIFT;
	localparam int CNT_W = MAX_AVG_SHIFT + 1;

	logic [1:0]                        last_ch_q;
	logic [SUM_W-1:0]                  sum_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [aam_pkg::AVG_SHIFT_W-1:0]   shift_eff;
	logic                              match;
	logic [SUM_W-1:0]                  sum_add;
	logic [CNT_W-1:0]                  cnt_add;
	logic [CNT_W-1:0]                  thresh;
	logic                              full;

	always_comb begin
		shift_eff = (avg_shift > aam_pkg::AVG_SHIFT_W'(MAX_AVG_SHIFT))
			? aam_pkg::AVG_SHIFT_W'(MAX_AVG_SHIFT) : avg_shift;
		match   = ({1'b0, channel} == last_ch_q);
		sum_add = sum_q + SUM_W'(sample);
		cnt_add = cnt_q + CNT_W'(1);
		thresh  = CNT_W'(1) << shift_eff;
		// A shift lowered mid-measurement makes the count overshoot; >= catches it.
		full    = (cnt_add >= thresh);
		done    = accept && match && full;
		avg     = sum_add >> shift_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ch_q <= aam_pkg::NO_CHANNEL;
			sum_q     <= '0;
			cnt_q     <= '0;
		end else if (accept) begin
			if (!match) begin
				// Settling read after a channel switch: restart the measurement.
				last_ch_q <= {1'b0, channel};
				sum_q     <= '0;
				cnt_q     <= '0;
			end else if (full) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_add;
				cnt_q <= cnt_add;
			end
		end
	end

endmodule

`default_nettype wire

### sv/aam_div.sv
`default_nettype none

`include "adc_average_to_millivolts_macros.svh"

module aam_div #(
	parameter int N_W = 30,
	parameter int D_W = 17
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [N_W-1:0]     dividend,
	input  wire logic [D_W-1:0]     divisor,
	output logic [N_W-1:0]          quotient,
	output aam_pkg::div_stat_t      stat
);

	localparam int CNT_W = $clog2(N_W);

	logic [D_W-1:0]   rem_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     shifted;
	logic [D_W:0]     trial;
	logic             ge;

	// One restoring step per cycle: one quotient bit from the dividend MSB down.
	always_comb begin
		shifted = {rem_q, quo_q[N_W-1]};
		trial   = shifted - {1'b0, div_q};
		ge      = (shifted >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[D_W-1:0] : shifted[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`AAM_ASSERT_IMP(a_start_when_free, clk, arst_n, start, !busy_q, "divider started while busy")
	`AAM_ASSERT_NXT(a_done_ends_busy, clk, arst_n, done_q, !busy_q && !done_q, "divider done is not a single-cycle end of a run")

endmodule

`default_nettype wire
